// ===== rtl/b5uao_pkg.sv =====
`default_nettype none

package b5uao_pkg;

   localparam int unsigned DEFAULT_TABLE_DEPTH = 32768;

   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_B2U  = 2'd1;
   localparam logic [1:0] FUNC_U2B  = 2'd2;

   localparam logic [7:0]  REPL_LEAD   = 8'hA1;
   localparam logic [7:0]  REPL_TRAIL  = 8'hBC;
   localparam logic [15:0] ASCII_LIMIT = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

   typedef struct packed {
      logic [1:0]  func;
      logic [14:0] entry_index;
      logic [15:0] big5_code;
      logic [15:0] unicode_unit;
   } b5uao_req_type;

   typedef struct packed {
      logic       status;
      logic [1:0] out_len;
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
   } b5uao_rsp_type;

   typedef struct packed {
      logic        b2u;
      logic        found;
      logic [15:0] key;
      logic [31:0] entry;
   } b5uao_res_type;

endpackage

`default_nettype wire

// ===== rtl/b5uao_engine.sv =====
`default_nettype none

module b5uao_engine #(
   parameter int unsigned TABLE_DEPTH = b5uao_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_fire,
   input  b5uao_pkg::b5uao_req_type req_data,
   input  logic [15:0]              limit_cfg,
   input  logic                     take,
   output logic                     idle,
   output logic                     res_valid,
   output b5uao_pkg::b5uao_res_type res_data
);
   import b5uao_pkg::*;

   localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type         state_ff, state_in;
   logic [CntW-1:0]   issue_ff, issue_in;
   logic [CntW-1:0]   cmp_ff, cmp_in;
   logic [CntW-1:0]   limit_ff, limit_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              b2u_ff, b2u_in;
   logic              found_ff, found_in;
   logic [15:0]       key_ff, key_in;
   logic [31:0]       entry_ff, entry_in;

   logic [31:0]       map_table_ff [TABLE_DEPTH];
   logic [31:0]       rd_data_ff;

   logic [16:0]       cfg_wide;
   logic [16:0]       depth_wide;
   logic [16:0]       lim_wide;
   logic [16:0]       idx_wide;
   logic [CntW-1:0]   limit_now;
   logic              wr_en;
   logic [AddrW-1:0]  wr_addr;
   logic [AddrW-1:0]  rd_addr;
   logic              is_search;
   logic              skip;
   logic              hit;

   assign cfg_wide   = {1'b0, limit_cfg};
   assign depth_wide = 17'(TABLE_DEPTH);
   assign lim_wide   = (cfg_wide > depth_wide) ? depth_wide : cfg_wide;
   assign limit_now  = lim_wide[CntW-1:0];

   assign idx_wide = 17'(req_data.entry_index);
   assign wr_en    = req_fire && (req_data.func == FUNC_LOAD) && (idx_wide < depth_wide);
   assign wr_addr  = idx_wide[AddrW-1:0];
   assign rd_addr  = issue_ff[AddrW-1:0];

   assign is_search = req_fire && ((req_data.func == FUNC_B2U) || (req_data.func == FUNC_U2B));
   assign skip = ((req_data.func == FUNC_B2U) && !req_data.big5_code[15])
              || ((req_data.func == FUNC_U2B) && (req_data.unicode_unit[15:11] == 5'b11011))
              || (limit_now == '0);

   assign hit = b2u_ff ? (rd_data_ff[31:16] == key_ff) : (rd_data_ff[15:0] == key_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_table_ff[wr_addr] <= {req_data.big5_code, req_data.unicode_unit};
      end
      rd_data_ff <= map_table_ff[rd_addr];
   end

   always_comb begin
      state_in  = state_ff;
      issue_in  = issue_ff;
      cmp_in    = cmp_ff;
      limit_in  = limit_ff;
      rd_vld_in = 1'b0;
      b2u_in    = b2u_ff;
      found_in  = found_ff;
      key_in    = key_ff;
      entry_in  = entry_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_search) begin
               b2u_in   = (req_data.func == FUNC_B2U);
               key_in   = (req_data.func == FUNC_B2U) ? req_data.big5_code
                                                      : req_data.unicode_unit;
               limit_in = limit_now;
               issue_in = '0;
               cmp_in   = '0;
               found_in = 1'b0;
               entry_in = '0;
               state_in = skip ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff < limit_ff) begin
               issue_in  = CntW'(issue_ff + 1'b1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               cmp_in = CntW'(cmp_ff + 1'b1);
               if (hit) begin
                  found_in  = 1'b1;
                  entry_in  = rd_data_ff;
                  rd_vld_in = 1'b0;
                  state_in  = ST_DONE;
               end else if (CntW'(cmp_ff + 1'b1) == limit_ff) begin
                  rd_vld_in = 1'b0;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
      issue_ff <= issue_in;
      cmp_ff   <= cmp_in;
      limit_ff <= limit_in;
      b2u_ff   <= b2u_in;
      found_ff <= found_in;
      key_ff   <= key_in;
      entry_ff <= entry_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res_data.b2u   = b2u_ff;
      res_data.found = found_ff;
      res_data.key   = key_ff;
      res_data.entry = entry_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/big5_uao_unicode_converter.sv =====
`default_nettype none

// Big5 (UAO) to and from Unicode converter over a loaded mapping table of TABLE_DEPTH
// entries held in one memory with a single read port; the table contents are undefined until
// loaded, there is no clearing pass, so only loaded positions may lie below entries_in_use. A
// load request or an unused function code is taken without occupying the engine and gives no
// response. A search request compares one table entry per cycle, in index order, and stops at
// the first match or after min(entries_in_use, TABLE_DEPTH) entries, and no new request is
// taken until its result has moved into the output register; a Big5 code without bit 7 in its
// lead byte, a lone surrogate unit or an empty table skips the scan entirely. The response
// sits in an output register, so the next request is taken while it waits; a finished search
// holds the input stalled until that register is free. The user must see that
// entries_in_use is written only while the block is idle; the block itself does not enforce it.
module big5_uao_unicode_converter #(
   parameter int unsigned TABLE_DEPTH = b5uao_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  b5uao_pkg::b5uao_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output b5uao_pkg::b5uao_rsp_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [15:0]              csr_data
);
   import b5uao_pkg::*;

   logic [15:0]   entries_ff, entries_in;
   logic          rsp_valid_ff, rsp_valid_in;
   b5uao_rsp_type rsp_data_ff, rsp_data_in;

   logic          req_fire;
   logic          eng_idle;
   logic          eng_res_valid;
   b5uao_res_type eng_res;
   logic          take;
   logic [15:0]   unit;

   assign csr_ready = 1'b1;
   assign req_stall = !eng_idle;
   assign req_fire  = req_valid && !req_stall;
   assign take      = eng_res_valid && (!rsp_valid_ff || !rsp_stall);

   b5uao_engine #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_data  (req_data),
      .limit_cfg (entries_ff),
      .take      (take),
      .idle      (eng_idle),
      .res_valid (eng_res_valid),
      .res_data  (eng_res)
   );

   assign entries_in = (csr_valid && csr_ready) ? csr_data : entries_ff;
   assign unit       = eng_res.entry[15:0];

   // utf-8 encoding, big5 output bytes and fallback bytes
   always_comb begin
      rsp_data_in = '0;
      if (eng_res.b2u) begin
         priority if (!eng_res.found || (unit[15:11] == 5'b11011)) begin
            rsp_data_in.status = 1'b1;
         end else if (unit == '0) begin
            rsp_data_in.out_len = 2'd0;
         end else if (unit < ASCII_LIMIT) begin
            rsp_data_in.out_len   = 2'd1;
            rsp_data_in.out_byte0 = unit[7:0];
         end else if (unit < TWO_BYTE_LIMIT) begin
            rsp_data_in.out_len   = 2'd2;
            rsp_data_in.out_byte0 = {3'b110, unit[10:6]};
            rsp_data_in.out_byte1 = {2'b10, unit[5:0]};
         end else begin
            rsp_data_in.out_len   = 2'd3;
            rsp_data_in.out_byte0 = {4'b1110, unit[15:12]};
            rsp_data_in.out_byte1 = {2'b10, unit[11:6]};
            rsp_data_in.out_byte2 = {2'b10, unit[5:0]};
         end
      end else begin
         priority if (eng_res.found) begin
            rsp_data_in.out_len   = 2'd2;
            rsp_data_in.out_byte0 = eng_res.entry[31:24];
            rsp_data_in.out_byte1 = eng_res.entry[23:16];
         end else if (eng_res.key < ASCII_LIMIT) begin
            rsp_data_in.out_len   = 2'd1;
            rsp_data_in.out_byte0 = eng_res.key[7:0];
         end else begin
            rsp_data_in.out_len   = 2'd2;
            rsp_data_in.out_byte0 = REPL_LEAD;
            rsp_data_in.out_byte1 = REPL_TRAIL;
         end
      end
   end

   always_comb begin
      priority if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_search_busy : assert property (@(posedge clock) disable iff (reset)
      (req_fire && ((req_data.func == FUNC_B2U) || (req_data.func == FUNC_U2B)))
      |=> !eng_idle)
      else $error("search request did not occupy the engine");

   a_load_idle : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.func == FUNC_LOAD)) |=> (eng_idle && !eng_res_valid))
      else $error("load request produced engine activity");

   a_take_fills : assert property (@(posedge clock) disable iff (reset)
      take |=> (rsp_valid_ff && eng_idle))
      else $error("handed-off response not registered");

   a_status_len : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (rsp_data.out_len == 2'd0))
      else $error("failed response carries bytes");

endmodule

`default_nettype wire
